FILE: hdl/mplp_pkg.sv
// mplp_pkg: types and constants shared by the madt processor list parser
// result record layout, table offsets and record type codes; no dependencies
package mplp_pkg;

  localparam logic [31:0] OFF_LEN_LO     = 32'd4;
  localparam logic [31:0] OFF_LEN_HI     = 32'd7;
  localparam logic [31:0] OFF_SIZE_READY = 32'd8;
  localparam logic [31:0] OFF_END_FIRST  = 32'd9;
  localparam logic [31:0] OFF_LAPIC_LO   = 32'd36;
  localparam logic [31:0] OFF_LAPIC_HI   = 32'd39;
  localparam logic [31:0] ENTRIES_START  = 32'd44;

  localparam logic [7:0] REC_LAPIC  = 8'd0;
  localparam logic [7:0] REC_X2APIC = 8'd9;

  localparam logic [7:0] LAPIC_ID_REL    = 8'd3;
  localparam logic [7:0] LAPIC_FLAG_REL  = 8'd4;
  localparam logic [7:0] LAPIC_LAST_REL  = 8'd7;
  localparam logic [7:0] LAPIC_MIN_SIZE  = 8'd8;
  localparam logic [7:0] X2_ID_LO_REL    = 8'd4;
  localparam logic [7:0] X2_ID_HI_REL    = 8'd7;
  localparam logic [7:0] X2_FLAG_REL     = 8'd8;
  localparam logic [7:0] X2_LAST_REL     = 8'd11;
  localparam logic [7:0] X2_MIN_SIZE     = 8'd12;
  localparam logic [7:0] REC_MIN_SIZE    = 8'd2;

  localparam logic [7:0] MAX_PROC_RESET = 8'd64;

  typedef enum logic {
    KIND_CPU     = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [31:0]  apic_id;
    logic         cpu_enabled;
    logic [31:0]  lapic_address;
    logic [7:0]   cpu_count;
    logic         list_truncated;
    logic         parse_ok;
    logic         last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: hdl/mplp_in_if.sv
// mplp_in_if: byte channel into the madt processor list parser
// valid/ready handshake with table byte and start marker; no dependencies
interface mplp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       start_of_table;

  modport source (output valid, output table_byte, output start_of_table, input ready);
  modport sink   (input valid, input table_byte, input start_of_table, output ready);
endinterface

FILE: hdl/mplp_out_if.sv
// mplp_out_if: result channel out of the madt processor list parser
// valid/ready handshake with processor and summary fields; no dependencies
interface mplp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] apic_id;
  logic        cpu_enabled;
  logic [31:0] lapic_address;
  logic [7:0]  cpu_count;
  logic        list_truncated;
  logic        parse_ok;
  logic        last_of_run;

  modport source (output valid, output result_kind, output apic_id, output cpu_enabled,
                  output lapic_address, output cpu_count, output list_truncated,
                  output parse_ok, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input apic_id, input cpu_enabled,
                  input lapic_address, input cpu_count, input list_truncated,
                  input parse_ok, input last_of_run, output ready);
endinterface

FILE: hdl/mplp_parse.sv
// mplp_parse: input register, table walk state and per-byte result logic
// depends on mplp_pkg; produces up to two results per byte for the queue
module mplp_parse import mplp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_transfer,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output push_t      push
);

  logic        stg_valid_r;
  logic [7:0]  stg_byte_r;
  logic        stg_start_r;
  logic [7:0]  max_r;

  logic [31:0] off_r, off_nxt;
  logic [31:0] tsize_r, tsize_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  rel_r, rel_nxt;
  logic [7:0]  rtype_r, rtype_nxt;
  logic [7:0]  rsize_r, rsize_nxt;
  logic [31:0] id_r, id_nxt;
  logic [1:0]  flag_r, flag_nxt;
  logic [31:0] lapic_r, lapic_nxt;
  logic [7:0]  kept_r, kept_nxt;
  logic        ovf_r, ovf_nxt;
  logic        halted_r, halted_nxt;
  logic        done_r, done_nxt;

  logic [31:0] o;
  logic [7:0]  b;
  logic [7:0]  size_eff;
  logic        fire;
  result_t     summ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      max_r       <= MAX_PROC_RESET;
      off_r       <= '0;
      tsize_r     <= '0;
      rel_r       <= '0;
      kept_r      <= '0;
      ovf_r       <= 1'b0;
      halted_r    <= 1'b0;
      done_r      <= 1'b1;
    end else begin
      stg_valid_r <= in_transfer;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      off_r    <= off_nxt;
      tsize_r  <= tsize_nxt;
      rel_r    <= rel_nxt;
      kept_r   <= kept_nxt;
      ovf_r    <= ovf_nxt;
      halted_r <= halted_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_transfer) begin
      stg_byte_r  <= in_byte;
      stg_start_r <= in_start;
    end
    last_r  <= last_nxt;
    rem_r   <= rem_nxt;
    rtype_r <= rtype_nxt;
    rsize_r <= rsize_nxt;
    id_r    <= id_nxt;
    flag_r  <= flag_nxt;
    lapic_r <= lapic_nxt;
  end

  always_comb begin
    off_nxt    = off_r;
    tsize_nxt  = tsize_r;
    last_nxt   = last_r;
    rem_nxt    = rem_r;
    rel_nxt    = rel_r;
    rtype_nxt  = rtype_r;
    rsize_nxt  = rsize_r;
    id_nxt     = id_r;
    flag_nxt   = flag_r;
    lapic_nxt  = lapic_r;
    kept_nxt   = kept_r;
    ovf_nxt    = ovf_r;
    halted_nxt = halted_r;
    done_nxt   = done_r;
    push       = '0;
    summ       = '0;
    o          = off_r;
    b          = stg_byte_r;
    size_eff   = rsize_r;
    fire       = 1'b0;

    if (stg_valid_r && (stg_start_r || !done_r)) begin
      if (stg_start_r) begin
        off_nxt    = '0;
        tsize_nxt  = '0;
        rel_nxt    = '0;
        rtype_nxt  = '0;
        rsize_nxt  = '0;
        id_nxt     = '0;
        flag_nxt   = '0;
        lapic_nxt  = '0;
        kept_nxt   = '0;
        ovf_nxt    = 1'b0;
        halted_nxt = 1'b0;
        done_nxt   = 1'b0;
      end
      o = off_nxt;

      if (o >= OFF_LEN_LO && o <= OFF_LEN_HI) begin
        tsize_nxt[{o[1:0], 3'b000} +: 8] = b;
      end else if (o >= OFF_LAPIC_LO && o <= OFF_LAPIC_HI) begin
        lapic_nxt[{o[1:0], 3'b000} +: 8] = b;
      end

      if (o == OFF_LEN_HI && tsize_nxt < ENTRIES_START) begin
        // table too short for any record
        lapic_nxt                = '0;
        summ.result_kind         = KIND_SUMMARY;
        summ.last_of_run         = 1'b1;
        push.first               = summ;
        push.n                   = 2'd1;
        done_nxt                 = 1'b1;
      end else begin
        if (o == OFF_SIZE_READY) begin
          last_nxt = tsize_r - 32'd1;
          rem_nxt  = tsize_r - ENTRIES_START;
        end

        // record walk: rem_r holds bytes from the current record start to table end
        if (o >= ENTRIES_START && !halted_r && (rem_r[31:1] != '0)) begin
          if (rel_r == '0) begin
            rtype_nxt = b;
            id_nxt    = '0;
            flag_nxt  = '0;
            rel_nxt   = 8'd1;
          end else begin
            if (rel_r == 8'd1) begin
              size_eff  = b;
              rsize_nxt = b;
            end
            if (rel_r == 8'd1 && (b < REC_MIN_SIZE || {24'd0, b} > rem_r)) begin
              halted_nxt = 1'b1;
            end else begin
              if (rtype_r == REC_LAPIC) begin
                if (rel_r == LAPIC_ID_REL) begin
                  id_nxt = {24'd0, b};
                end
                if (rel_r == LAPIC_FLAG_REL) begin
                  flag_nxt = b[1:0];
                end
                fire = (rel_r == LAPIC_LAST_REL) && (size_eff >= LAPIC_MIN_SIZE);
              end else if (rtype_r == REC_X2APIC) begin
                if (rel_r >= X2_ID_LO_REL && rel_r <= X2_ID_HI_REL) begin
                  id_nxt[{rel_r[1:0], 3'b000} +: 8] = b;
                end
                if (rel_r == X2_FLAG_REL) begin
                  flag_nxt = b[1:0];
                end
                fire = (rel_r == X2_LAST_REL) && (size_eff >= X2_MIN_SIZE);
              end

              if (fire) begin
                if (kept_r >= max_r) begin
                  ovf_nxt = 1'b1;
                end else begin
                  kept_nxt                    = 8'(kept_r + 8'd1);
                  push.first.result_kind      = KIND_CPU;
                  push.first.apic_id          = id_r;
                  push.first.cpu_enabled      = (flag_r != 2'b00);
                  push.first.lapic_address    = lapic_r;
                  push.first.cpu_count        = 8'(kept_r + 8'd1);
                  push.first.list_truncated   = ovf_r;
                  push.first.parse_ok         = 1'b1;
                  push.first.last_of_run      = 1'b1;
                  push.n                      = 2'd1;
                end
              end

              if (rel_r == 8'(size_eff - 8'd1)) begin
                rem_nxt = rem_r - {24'd0, size_eff};
                rel_nxt = '0;
              end else begin
                rel_nxt = 8'(rel_r + 8'd1);
              end
            end
          end
        end

        if (o >= OFF_END_FIRST && o == last_r) begin
          summ.result_kind    = KIND_SUMMARY;
          summ.lapic_address  = lapic_nxt;
          summ.cpu_count      = kept_nxt;
          summ.list_truncated = ovf_nxt;
          summ.parse_ok       = (kept_nxt != '0);
          summ.last_of_run    = 1'b1;
          done_nxt            = 1'b1;
          if (push.n == 2'd1) begin
            push.first.last_of_run = 1'b0;
            push.second            = summ;
            push.n                 = 2'd2;
          end else begin
            push.first = summ;
            push.n     = 2'd1;
          end
        end

        off_nxt = o + 32'd1;
      end
    end
  end

endmodule

FILE: hdl/mplp_result_fifo.sv
// mplp_result_fifo: result queue taking up to two results per cycle
// depends on mplp_pkg; DEPTH must be a power of two, at least 4
module mplp_result_fifo import mplp_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  push_t                    push,
  input  logic                     pop,
  output result_t                  head,
  output logic                     not_empty,
  output logic                     room,
  output logic [$clog2(DEPTH):0]   level
);

  localparam int AW = $clog2(DEPTH);

  result_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     level_r;
  logic            do_pop;

  assign do_pop    = pop && (level_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (level_r != '0);
  // room for up to two results from the byte in the stage register plus two from a new byte
  assign room      = (level_r <= (AW + 1)'(DEPTH - 4));
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push.n);
      rd_ptr_r <= rd_ptr_r + AW'(do_pop);
      level_r  <= level_r + (AW + 1)'(push.n) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem_r[AW'(wr_ptr_r + AW'(1))] <= push.second;
    end
  end

endmodule

FILE: hdl/madt_processor_list_parser.sv
// madt_processor_list_parser: top level, one madt byte per transfer in
// path: a byte taken in is held in the stage register; its results are written into
//   the result queue, from whose head the first transfers out and a second follows it
// throughput: one byte per cycle; in_chan.ready drops while the result queue
//   holds more than RESULT_DEPTH-4 results
// reset: rst_n synchronous, active low; max_processors back to 64, queue empty, parser idle
module madt_processor_list_parser import mplp_pkg::*; #(
  parameter int RESULT_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  mplp_in_if.sink      in_chan,
  mplp_out_if.source   out_chan,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  push_t                         push;
  result_t                       head;
  logic                          q_not_empty;
  logic                          q_room;
  logic [$clog2(RESULT_DEPTH):0] q_level;
  logic                          in_transfer;
  logic                          out_transfer;

  assign in_chan.ready = q_room;
  assign in_transfer   = in_chan.valid && q_room;
  assign out_transfer  = q_not_empty && out_chan.ready;

  mplp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_transfer (in_transfer),
    .in_byte     (in_chan.table_byte),
    .in_start    (in_chan.start_of_table),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  mplp_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_chan.ready),
    .head      (head),
    .not_empty (q_not_empty),
    .room      (q_room),
    .level     (q_level)
  );

  assign out_chan.valid          = q_not_empty;
  assign out_chan.result_kind    = head.result_kind;
  assign out_chan.apic_id        = head.apic_id;
  assign out_chan.cpu_enabled    = head.cpu_enabled;
  assign out_chan.lapic_address  = head.lapic_address;
  assign out_chan.cpu_count      = head.cpu_count;
  assign out_chan.list_truncated = head.list_truncated;
  assign out_chan.parse_ok       = head.parse_ok;
  assign out_chan.last_of_run    = head.last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= ($clog2(RESULT_DEPTH) + 1)'(RESULT_DEPTH))
    else $error("result queue overrun");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_transfer && out_chan.result_kind == KIND_SUMMARY) |-> out_chan.last_of_run)
    else $error("summary not last of run");

  a_cpu_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_transfer && out_chan.result_kind == KIND_CPU)
      |-> (out_chan.parse_ok && out_chan.cpu_count != 8'd0))
    else $error("processor result without count");

endmodule

FILE: tb/madt_processor_list_parser_tb.sv
// madt_processor_list_parser_tb: self-checking bench for the madt processor list parser
// streams whole and broken tables byte by byte, predicts every result in step with the input
// depends on mplp_pkg, mplp_in_if, mplp_out_if and madt_processor_list_parser
`timescale 1ns / 100ps

module madt_processor_list_parser_tb;
  import mplp_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] value;
    logic       sof;
  } madt_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  mplp_in_if  in_if();
  mplp_out_if out_if();

  madt_processor_list_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  madt_byte_t pending_bytes[$];
  result_t    expected_results[$];
  result_t    step_out[$];
  logic [7:0] madt_img[$];

  int bytes_queued;
  int bytes_taken;
  int fail_count;
  int quiet_cycles;
  int src_gap;
  int sink_gap;
  bit src_steady;
  bit sink_steady;
  logic sink_hold;
  madt_byte_t next_byte;
  result_t got;
  result_t want;

  // parser image
  logic [7:0]  cap_procs;
  logic [31:0] p_off;
  logic [31:0] p_len;
  logic [31:0] p_rec_at;
  logic [7:0]  p_rec_type;
  logic [7:0]  p_rec_len;
  logic [31:0] p_id;
  logic [31:0] p_flags;
  logic [31:0] p_lapic;
  logic [7:0]  p_kept;
  logic        p_over;
  logic        p_halted;
  logic        p_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t make_result(result_kind_t kind, logic [31:0] id, logic en,
                                          logic [31:0] lapic, logic ok);
    result_t r;
    r.result_kind    = kind;
    r.apic_id        = id;
    r.cpu_enabled    = en;
    r.lapic_address  = lapic;
    r.cpu_count      = p_kept;
    r.list_truncated = p_over;
    r.parse_ok       = ok;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  function automatic string result_text(result_t r);
    return $sformatf("kind=%0d id=%h en=%0d lapic=%h count=%0d trunc=%0d ok=%0d last=%0d",
                     r.result_kind, r.apic_id, r.cpu_enabled, r.lapic_address, r.cpu_count,
                     r.list_truncated, r.parse_ok, r.last_of_run);
  endfunction

  task automatic keep_cpu();
    if (p_kept >= cap_procs) begin
      p_over = 1'b1;
    end else begin
      p_kept = p_kept + 8'd1;
      step_out.push_back(make_result(KIND_CPU, p_id, |p_flags[1:0], p_lapic, 1'b1));
    end
  endtask

  task automatic predict_madt_byte(input logic [7:0] b, input logic sof);
    logic [31:0] o;
    logic [31:0] rel;
    logic        stop;
    step_out.delete();
    if (sof) begin
      p_off      = '0;
      p_len      = '0;
      p_rec_at   = ENTRIES_START;
      p_rec_type = '0;
      p_rec_len  = '0;
      p_id       = '0;
      p_flags    = '0;
      p_lapic    = '0;
      p_kept     = '0;
      p_over     = 1'b0;
      p_halted   = 1'b0;
      p_done     = 1'b0;
    end else if (p_done) begin
      return;
    end
    o = p_off;
    if (o >= OFF_LEN_LO && o <= OFF_LEN_HI) begin
      p_len = p_len | (32'(b) << (8 * (o - OFF_LEN_LO)));
    end else if (o >= OFF_LAPIC_LO && o <= OFF_LAPIC_HI) begin
      p_lapic = p_lapic | (32'(b) << (8 * (o - OFF_LAPIC_LO)));
    end
    if (o == OFF_LEN_HI && p_len < ENTRIES_START) begin
      // length too short for any record: summary straight away
      p_lapic = '0;
      step_out.push_back(make_result(KIND_SUMMARY, '0, 1'b0, '0, 1'b0));
      p_done = 1'b1;
    end else begin
      if (o >= ENTRIES_START && !p_halted && 64'(p_rec_at) + 64'd2 <= 64'(p_len) &&
          o >= p_rec_at) begin
        rel = o - p_rec_at;
        if (rel == 0) begin
          p_rec_type = b;
          p_id       = '0;
          p_flags    = '0;
        end else begin
          stop = 1'b0;
          if (rel == 1) begin
            p_rec_len = b;
            if (b < REC_MIN_SIZE || 64'(p_rec_at) + 64'(b) > 64'(p_len)) begin
              p_halted = 1'b1;
              stop     = 1'b1;
            end
          end
          if (!stop) begin
            if (p_rec_type == REC_LAPIC) begin
              if (rel == 32'(LAPIC_ID_REL)) begin
                p_id = 32'(b);
              end else if (rel >= 4 && rel <= 7) begin
                p_flags = p_flags | (32'(b) << (8 * (rel - 4)));
              end
              if (rel == 32'(LAPIC_LAST_REL) && p_rec_len >= LAPIC_MIN_SIZE) keep_cpu();
            end else if (p_rec_type == REC_X2APIC) begin
              if (rel >= 4 && rel <= 7) begin
                p_id = p_id | (32'(b) << (8 * (rel - 4)));
              end else if (rel >= 8 && rel <= 11) begin
                p_flags = p_flags | (32'(b) << (8 * (rel - 8)));
              end
              if (rel == 32'(X2_LAST_REL) && p_rec_len >= X2_MIN_SIZE) keep_cpu();
            end
            if (rel == 32'(p_rec_len) - 32'd1) p_rec_at = p_rec_at + 32'(p_rec_len);
          end
        end
      end
      if (o >= OFF_LEN_HI && o == p_len - 32'd1) begin
        step_out.push_back(make_result(KIND_SUMMARY, '0, 1'b0, p_lapic, p_kept != 0));
        p_done = 1'b1;
      end
      p_off = o + 32'd1;
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // byte source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_madt_byte(in_if.table_byte, in_if.start_of_table);
        bytes_taken++;
        if ($urandom_range(0, 49) == 0) src_steady = !src_steady;
        src_gap = src_steady ? 0 : $urandom_range(0, 12);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_if.valid          <= 1'b1;
          in_if.table_byte     <= next_byte.value;
          in_if.start_of_table <= next_byte.sof;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.result_kind    = result_kind_t'(out_if.result_kind);
        got.apic_id        = out_if.apic_id;
        got.cpu_enabled    = out_if.cpu_enabled;
        got.lapic_address  = out_if.lapic_address;
        got.cpu_count      = out_if.cpu_count;
        got.list_truncated = out_if.list_truncated;
        got.parse_ok       = out_if.parse_ok;
        got.last_of_run    = out_if.last_of_run;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected result: %s", result_text(got)));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            log_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                  result_text(want), result_text(got)));
          end
        end
        if ($urandom_range(0, 29) == 0) sink_steady = !sink_steady;
        sink_gap = sink_steady ? 0 : $urandom_range(0, 12);
      end else if (sink_gap > 0) begin
        sink_gap--;
      end
      out_if.ready <= (sink_gap == 0) && !sink_hold;
    end
  end

  // long receiver stall while bytes keep coming
  initial begin
    sink_hold = 1'b0;
    wait (bytes_taken >= 650);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("madt_processor_list_parser_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] v, input logic sof);
    madt_byte_t item;
    item.value = v;
    item.sof   = sof;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic begin_madt(input logic [31:0] lapic);
    madt_img.delete();
    repeat (44) madt_img.push_back(8'($urandom()));
    for (int k = 0; k < 4; k++) madt_img[36 + k] = lapic[8 * k +: 8];
  endtask

  task automatic seal_madt(input logic [31:0] len);
    for (int k = 0; k < 4; k++) madt_img[4 + k] = len[8 * k +: 8];
  endtask

  task automatic pad_madt(input int n);
    repeat (n) madt_img.push_back(8'($urandom()));
  endtask

  task automatic add_record(input logic [7:0] kind, input logic [7:0] size,
                            input logic [31:0] id, input logic [31:0] flags);
    int n;
    logic [7:0] v;
    n = (size < 2) ? 2 : size;
    for (int k = 0; k < n; k++) begin
      v = 8'($urandom());
      if (k == 0) begin
        v = kind;
      end else if (k == 1) begin
        v = size;
      end else if (kind == REC_LAPIC) begin
        if (k == 3) v = id[7:0];
        else if (k >= 4 && k <= 7) v = flags[8 * (k - 4) +: 8];
      end else if (kind == REC_X2APIC) begin
        if (k >= 4 && k <= 7) v = id[8 * (k - 4) +: 8];
        else if (k >= 8 && k <= 11) v = flags[8 * (k - 8) +: 8];
      end
      madt_img.push_back(v);
    end
  endtask

  task automatic ship_madt(input int first, input int last);
    if (last > madt_img.size()) last = madt_img.size();
    for (int k = first; k < last; k++) push_byte(madt_img[k], k == 0);
  endtask

  task automatic random_madt();
    int nrec;
    int pick;
    int total;
    int cut;
    logic [31:0] len;
    logic [31:0] flg;
    logic [7:0]  other;
    begin_madt($urandom());
    nrec = $urandom_range(0, 9);
    repeat (nrec) begin
      pick = $urandom_range(0, 99);
      flg = $urandom();
      if ($urandom_range(0, 2) == 0) flg[1:0] = 2'b00;
      other = 8'($urandom_range(1, 255));
      if (other == REC_X2APIC) other = 8'd10;
      if (pick < 50) begin
        add_record(REC_LAPIC, 8'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : 8),
                   $urandom(), flg);
      end else if (pick < 78) begin
        add_record(REC_X2APIC, 8'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : 12),
                   $urandom(), flg);
      end else if (pick < 88) begin
        add_record(other, 8'($urandom_range(2, 16)), $urandom(), flg);
      end else if (pick < 96) begin
        if (pick[0]) add_record(REC_LAPIC, 8'($urandom_range(2, 7)), $urandom(), flg);
        else add_record(REC_X2APIC, 8'($urandom_range(2, 11)), $urandom(), flg);
      end else begin
        add_record(pick[0] ? REC_LAPIC : other, 8'($urandom_range(0, 1)), $urandom(), flg);
      end
    end
    total = madt_img.size();
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      len = total;
    end else if (pick < 84) begin
      pad_madt(1);
      len = total + 1;
    end else if (pick < 89) begin
      pad_madt(pick - 82);
      len = madt_img.size();
    end else if (pick < 93 && total > 47) begin
      len = total - $urandom_range(1, 3);
    end else if (pick < 97) begin
      len = $urandom_range(0, 43);
    end else begin
      len = $urandom();
    end
    seal_madt(len);
    cut = madt_img.size();
    if ($urandom_range(0, 24) == 0) cut = $urandom_range(1, cut);
    ship_madt(0, cut);
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom()), 1'b0);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cap(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cap_procs   = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] cap_plan [0:5];
    int phase_end;
    in_if.valid          = 1'b0;
    in_if.table_byte     = '0;
    in_if.start_of_table = 1'b0;
    out_if.ready         = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    cap_procs            = MAX_PROC_RESET;
    p_done               = 1'b1;
    p_off                = '0;
    p_len                = '0;
    p_rec_at             = ENTRIES_START;
    p_kept               = '0;
    p_over               = 1'b0;
    p_halted             = 1'b0;
    bytes_queued         = 0;
    bytes_taken          = 0;
    fail_count           = 0;
    quiet_cycles         = 0;
    src_steady           = 1'b0;
    sink_steady          = 1'b0;
    rst_n                = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // idle bytes are dropped
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    // short table, summary at the length field
    begin_madt(32'hfee0_0000);
    seal_madt(43);
    ship_madt(0, 12);
    // header only
    begin_madt(32'hffff_ffff);
    seal_madt(44);
    ship_madt(0, 44);
    // every processor flavour, last record ends on the final byte
    begin_madt(32'h0000_0000);
    add_record(REC_LAPIC, 8, 32'h0000_00ff, 32'h0000_0001);
    add_record(REC_LAPIC, 8, 32'h0000_0000, 32'h0000_0000);
    add_record(REC_LAPIC, 10, 32'h0000_005a, 32'h0000_0002);
    add_record(REC_X2APIC, 12, 32'hffff_ffff, 32'h8000_0000);
    add_record(8'd5, 6, 32'h0, 32'h0);
    add_record(REC_LAPIC, 6, 32'h7, 32'h1);
    add_record(REC_X2APIC, 8, 32'h1234_5678, 32'h3);
    add_record(REC_X2APIC, 12, 32'h0000_0000, 32'hffff_ffff);
    seal_madt(madt_img.size());
    ship_madt(0, madt_img.size());
    // record length below two halts the walk
    begin_madt($urandom());
    add_record(REC_LAPIC, 8, 32'h11, 32'h1);
    add_record(8'd2, 1, 32'h0, 32'h0);
    add_record(REC_LAPIC, 8, 32'h22, 32'h1);
    seal_madt(madt_img.size());
    ship_madt(0, madt_img.size());
    // record runs past the table end
    begin_madt($urandom());
    add_record(REC_X2APIC, 12, 32'h33, 32'h1);
    add_record(REC_LAPIC, 8, 32'h44, 32'h1);
    seal_madt(madt_img.size() - 3);
    ship_madt(0, madt_img.size());
    // single trailing byte
    begin_madt($urandom());
    add_record(REC_LAPIC, 8, 32'h55, 32'h2);
    pad_madt(1);
    seal_madt(madt_img.size());
    ship_madt(0, madt_img.size());
    // restart in the middle of a table
    begin_madt($urandom());
    add_record(REC_LAPIC, 8, 32'h66, 32'h1);
    seal_madt(madt_img.size());
    ship_madt(0, 30);
    ship_madt(0, madt_img.size());
    wait_drained();

    // maximum lowered below the count already kept
    begin_madt($urandom());
    repeat (6) add_record(REC_LAPIC, 8, $urandom(), 32'h1);
    seal_madt(madt_img.size());
    ship_madt(0, 68);
    wait_drained();
    set_cap(8'd2);
    ship_madt(68, madt_img.size());

    cap_plan[0] = 8'd255;
    cap_plan[1] = 8'd0;
    cap_plan[2] = 8'd1;
    cap_plan[3] = 8'd64;
    cap_plan[4] = 8'd3;
    cap_plan[5] = 8'($urandom());
    for (int i = 0; i < 6; i++) begin
      wait_drained();
      set_cap(cap_plan[i]);
      phase_end = bytes_queued + 180;
      while (bytes_queued < phase_end) random_madt();
    end

    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("madt_processor_list_parser_tb: PASS");
    end else begin
      $display("madt_processor_list_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mplp_pkg.sv
hdl/mplp_in_if.sv
hdl/mplp_out_if.sv
hdl/mplp_parse.sv
hdl/mplp_result_fifo.sv
hdl/madt_processor_list_parser.sv
tb/madt_processor_list_parser_tb.sv
